@@ design/bbi2c_pkg.sv @@
// Shared types, codes and helpers for the bit-bang I2C master byte engine.
package bbi2c_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int CNT_W         = 4;
    localparam int TICK_W        = 8;
    localparam int CFG_IDX_W     = 3;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_START = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'd0,
        PH_START = 5'd1,
        PH_WHIGH = 5'd2,
        PH_WLOW  = 5'd3,
        PH_WACK  = 5'd4,
        PH_WEND  = 5'd5,
        PH_RPRE  = 5'd6,
        PH_RREL  = 5'd7,
        PH_RHIGH = 5'd8,
        PH_RSAMP = 5'd9,
        PH_RLOW  = 5'd10,
        PH_RACK  = 5'd11,
        PH_REND  = 5'd12
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HALF = 3'd0,
        CFG_PART = 3'd1,
        CFG_FULL = 3'd2,
        CFG_LONG = 3'd3
    } t_cfg_idx;

    // One classified tick, as queued between front and engine.
    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] load_byte;
        logic       ack_level;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic       acked;
        logic [7:0] read_byte;
    } t_result;

    // A zero tick count lasts one tick.
    function automatic logic [TICK_W-1:0] span(input logic [TICK_W-1:0] ticks);
        span = (ticks == '0) ? TICK_W'(1) : ticks;
    endfunction

endpackage

@@ design/bitbang_i2c_master_byte_engine_unit.sv @@
// Top level of the bit-bang I2C master byte engine: front queue, engine, assertions.
// Each input transaction is one timebase tick and yields exactly one result transaction.
// Ticks are taken one per clock cycle while nothing stalls: a two-entry queue sits between
// the input and the phase sequencer, and a result register sits after it, so a tick can be
// accepted while the previous result is still stalled. The rate is set by the phase
// sequencer, which updates its state for one tick at a time; a tick passes through the
// queue entry and then the result register before its result is presented. Commands
// (start, write, read) are acted on only while no command is running, otherwise ignored.
// Configuration writes (index 0 half, 1 part, 2 full, 3 long tick counts) are always
// ready and should be issued only while the engine is idle with no ticks in flight.
module bitbang_i2c_master_byte_engine_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_op,
    input  logic [7:0] i_cmd_byte,
    input  logic       i_read_not_write,
    input  logic       i_ack_level,
    input  logic       i_sda_in,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_scl_out,
    output logic       o_sda_level,
    output logic       o_sda_drive,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic       o_acked,
    output logic [7:0] o_read_byte,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [bbi2c_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    bbi2c_pkg::t_item   w_item;
    logic               w_item_valid;
    logic               w_item_take;
    bbi2c_pkg::t_result w_result;

    assign o_cfg_ready = 1'b1;

    bbi2c_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_op             (i_op),
        .i_cmd_byte       (i_cmd_byte),
        .i_read_not_write (i_read_not_write),
        .i_ack_level      (i_ack_level),
        .i_sda_in         (i_sda_in),
        .o_item           (w_item),
        .o_item_valid     (w_item_valid),
        .i_item_take      (w_item_take)
    );

    bbi2c_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item),
        .i_item_valid (w_item_valid),
        .o_item_take  (w_item_take),
        .i_cfg_valid  (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_out_stall  (i_stall),
        .o_out_valid  (o_valid),
        .o_result     (w_result)
    );

    assign o_scl_out   = w_result.scl_out;
    assign o_sda_level = w_result.sda_level;
    assign o_sda_drive = w_result.sda_drive;
    assign o_busy_res  = w_result.busy_res;
    assign o_done_res  = w_result.done_res;
    assign o_acked     = w_result.acked;
    assign o_read_byte = w_result.read_byte;

    a_take_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_item_take |-> w_item_valid)
        else $error("engine took a transaction from an empty queue");

    a_done_is_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_done_res) |-> !o_busy_res)
        else $error("command reported done while still busy");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("result or stall left pending after reset");

endmodule

@@ design/bbi2c_front.sv @@
// Front end: accepts ticks, classifies the command and queues them for the engine.
module bbi2c_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_op,
    input  logic [7:0]          i_cmd_byte,
    input  logic                i_read_not_write,
    input  logic                i_ack_level,
    input  logic                i_sda_in,
    output bbi2c_pkg::t_item    o_item,
    output logic                o_item_valid,
    input  logic                i_item_take
);

    bbi2c_pkg::t_item r_q [0:1];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic [1:0]       n_count;
    logic             w_push;
    bbi2c_pkg::t_item w_item;

    // Preload the shift byte the engine needs for each command.
    always_comb begin
        w_item.cmd       = bbi2c_pkg::t_cmd'(i_op);
        w_item.ack_level = i_ack_level;
        w_item.sda_in    = i_sda_in;
        case (w_item.cmd)
            bbi2c_pkg::CMD_START: w_item.load_byte = {i_cmd_byte[6:0], i_read_not_write};
            bbi2c_pkg::CMD_WRITE: w_item.load_byte = i_cmd_byte;
            default:              w_item.load_byte = '0;
        endcase
    end

    assign o_stall      = (r_count == 2'd2);
    assign w_push       = i_valid && !o_stall;
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_q[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (w_push && !i_item_take) begin
            n_count = r_count + 2'd1;
        end else if (!w_push && i_item_take) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_item_take) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

endmodule

@@ design/bbi2c_engine.sv @@
// Bus engine: phase sequencer, pin registers, tick registers and result register.
module bbi2c_engine (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bbi2c_pkg::t_item      i_item,
    input  logic                  i_item_valid,
    output logic                  o_item_take,
    input  logic                  i_cfg_valid,
    input  logic [bbi2c_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]            i_cfg_data,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output bbi2c_pkg::t_result    o_result
);

    logic [bbi2c_pkg::TICK_W-1:0] r_half_ticks, r_part_ticks, r_full_ticks, r_long_ticks;

    bbi2c_pkg::t_phase            r_phase, n_phase;
    logic [bbi2c_pkg::CNT_W-1:0]  r_bit_count, n_bit_count;
    logic [7:0]                   r_shift, n_shift;
    logic [bbi2c_pkg::TICK_W-1:0] r_tick, n_tick;
    logic                         r_ack_hold, n_ack_hold;
    logic                         r_ack_result, n_ack_result;
    logic                         r_scl, n_scl;
    logic                         r_sda, n_sda;
    logic                         r_sda_oe, n_sda_oe;
    logic [7:0]                   r_rx, n_rx;
    logic                         r_out_valid;
    bbi2c_pkg::t_result           r_out, n_out;

    logic                         w_fire;
    logic                         w_idle;
    logic                         w_enter;
    logic                         w_done;
    logic [bbi2c_pkg::TICK_W-1:0] w_tc;
    logic [bbi2c_pkg::CNT_W-1:0]  w_bit_inc;
    logic [7:0]                   w_shift_base;

    assign w_fire      = i_item_valid && (!r_out_valid || !i_out_stall);
    assign o_item_take = w_fire;
    assign w_idle      = (r_phase == bbi2c_pkg::PH_IDLE);
    assign w_tc        = r_tick - {{(bbi2c_pkg::TICK_W-1){1'b0}}, (r_tick != '0)};
    assign w_bit_inc   = r_bit_count + bbi2c_pkg::CNT_W'(1);

    // Next phase and bit counter.
    always_comb begin
        n_phase     = r_phase;
        n_bit_count = r_bit_count;
        w_enter     = 1'b0;
        w_done      = 1'b0;
        if (w_idle) begin
            case (i_item.cmd)
                bbi2c_pkg::CMD_START: begin
                    n_phase = bbi2c_pkg::PH_START;
                    w_enter = 1'b1;
                end
                bbi2c_pkg::CMD_WRITE: begin
                    n_phase     = bbi2c_pkg::PH_WHIGH;
                    n_bit_count = '0;
                    w_enter     = 1'b1;
                end
                bbi2c_pkg::CMD_READ: begin
                    n_phase     = bbi2c_pkg::PH_RPRE;
                    n_bit_count = '0;
                    w_enter     = 1'b1;
                end
                default: ;
            endcase
        end else if (w_tc == '0) begin
            w_enter = 1'b1;
            case (r_phase)
                bbi2c_pkg::PH_START: begin
                    n_bit_count = '0;
                    n_phase     = bbi2c_pkg::PH_WHIGH;
                end
                bbi2c_pkg::PH_WHIGH: n_phase = bbi2c_pkg::PH_WLOW;
                bbi2c_pkg::PH_WLOW: begin
                    n_bit_count = w_bit_inc;
                    n_phase = (w_bit_inc >= bbi2c_pkg::CNT_W'(bbi2c_pkg::BITS_PER_BYTE)) ?
                              bbi2c_pkg::PH_WACK : bbi2c_pkg::PH_WHIGH;
                end
                bbi2c_pkg::PH_WACK:  n_phase = bbi2c_pkg::PH_WEND;
                bbi2c_pkg::PH_RPRE:  n_phase = bbi2c_pkg::PH_RREL;
                bbi2c_pkg::PH_RREL: begin
                    n_bit_count = '0;
                    n_phase     = bbi2c_pkg::PH_RHIGH;
                end
                bbi2c_pkg::PH_RHIGH: n_phase = bbi2c_pkg::PH_RSAMP;
                bbi2c_pkg::PH_RSAMP: n_phase = bbi2c_pkg::PH_RLOW;
                bbi2c_pkg::PH_RLOW: begin
                    n_bit_count = w_bit_inc;
                    n_phase = (w_bit_inc >= bbi2c_pkg::CNT_W'(bbi2c_pkg::BITS_PER_BYTE)) ?
                              bbi2c_pkg::PH_RACK : bbi2c_pkg::PH_RHIGH;
                end
                bbi2c_pkg::PH_RACK:  n_phase = bbi2c_pkg::PH_REND;
                default: begin
                    // end of settling: drop back to idle
                    n_phase = bbi2c_pkg::PH_IDLE;
                    w_enter = 1'b0;
                    w_done  = 1'b1;
                end
            endcase
        end
    end

    // Pin, shift and tick updates applied on entry to a phase.
    always_comb begin
        w_shift_base = (w_idle && i_item.cmd != bbi2c_pkg::CMD_NONE) ? i_item.load_byte : r_shift;
        n_shift      = w_shift_base;
        n_ack_hold   = (w_idle && i_item.cmd == bbi2c_pkg::CMD_READ) ? i_item.ack_level
                                                                      : r_ack_hold;
        n_ack_result = r_ack_result;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_sda_oe     = r_sda_oe;
        n_rx         = r_rx;
        n_tick       = w_idle ? r_tick : w_tc;
        if (w_enter) begin
            case (n_phase)
                bbi2c_pkg::PH_START: begin
                    n_sda_oe = 1'b1;
                    n_sda    = 1'b0;
                    n_scl    = 1'b0;
                    n_tick   = bbi2c_pkg::span(r_full_ticks);
                end
                bbi2c_pkg::PH_WHIGH: begin
                    n_sda_oe = 1'b1;
                    n_sda    = w_shift_base[7];
                    n_scl    = 1'b1;
                    n_shift  = {w_shift_base[6:0], 1'b0};
                    n_tick   = bbi2c_pkg::span(r_half_ticks);
                end
                bbi2c_pkg::PH_WLOW: begin
                    n_scl  = 1'b0;
                    n_tick = bbi2c_pkg::span(r_half_ticks);
                end
                bbi2c_pkg::PH_WACK: begin
                    n_sda_oe     = 1'b0;
                    n_scl        = 1'b1;
                    n_ack_result = !i_item.sda_in;
                    if (!i_item.sda_in) begin
                        n_sda = 1'b0;
                    end
                    n_tick = bbi2c_pkg::span(r_half_ticks);
                end
                bbi2c_pkg::PH_WEND: begin
                    n_scl  = 1'b0;
                    n_tick = bbi2c_pkg::span(r_full_ticks);
                end
                bbi2c_pkg::PH_RPRE: begin
                    n_sda  = 1'b0;
                    n_tick = bbi2c_pkg::span(r_long_ticks);
                end
                bbi2c_pkg::PH_RREL: begin
                    n_sda_oe = 1'b0;
                    n_tick   = bbi2c_pkg::span(r_half_ticks);
                end
                bbi2c_pkg::PH_RHIGH: begin
                    n_shift = {w_shift_base[6:0], 1'b0};
                    n_scl   = 1'b1;
                    n_tick  = bbi2c_pkg::span(r_part_ticks);
                end
                bbi2c_pkg::PH_RSAMP: begin
                    n_shift = {w_shift_base[7:1], w_shift_base[0] | i_item.sda_in};
                    n_tick  = bbi2c_pkg::span(r_part_ticks);
                end
                bbi2c_pkg::PH_RLOW: begin
                    n_scl  = 1'b0;
                    n_tick = bbi2c_pkg::span(r_half_ticks);
                end
                bbi2c_pkg::PH_RACK: begin
                    // only reached from the last read bit: capture the byte
                    n_rx     = r_shift;
                    n_sda_oe = 1'b1;
                    n_sda    = r_ack_hold;
                    n_scl    = 1'b1;
                    n_tick   = bbi2c_pkg::span(r_half_ticks);
                end
                bbi2c_pkg::PH_REND: begin
                    n_scl  = 1'b0;
                    n_sda  = 1'b0;
                    n_tick = bbi2c_pkg::span(r_long_ticks);
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_out.scl_out   = n_scl;
        n_out.sda_level = n_sda;
        n_out.sda_drive = n_sda_oe;
        n_out.busy_res  = (n_phase != bbi2c_pkg::PH_IDLE);
        n_out.done_res  = w_done;
        n_out.acked     = n_ack_result;
        n_out.read_byte = n_rx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_ticks <= 8'd4;
            r_part_ticks <= 8'd2;
            r_full_ticks <= 8'd8;
            r_long_ticks <= 8'd10;
        end else if (i_cfg_valid) begin
            case (bbi2c_pkg::t_cfg_idx'(i_cfg_index))
                bbi2c_pkg::CFG_HALF: r_half_ticks <= i_cfg_data;
                bbi2c_pkg::CFG_PART: r_part_ticks <= i_cfg_data;
                bbi2c_pkg::CFG_FULL: r_full_ticks <= i_cfg_data;
                bbi2c_pkg::CFG_LONG: r_long_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= bbi2c_pkg::PH_IDLE;
            r_bit_count  <= '0;
            r_shift      <= '0;
            r_tick       <= '0;
            r_ack_hold   <= 1'b0;
            r_ack_result <= 1'b0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_sda_oe     <= 1'b1;
            r_rx         <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_fire) begin
                r_phase      <= n_phase;
                r_bit_count  <= n_bit_count;
                r_shift      <= n_shift;
                r_tick       <= n_tick;
                r_ack_hold   <= n_ack_hold;
                r_ack_result <= n_ack_result;
                r_scl        <= n_scl;
                r_sda        <= n_sda;
                r_sda_oe     <= n_sda_oe;
                r_rx         <= n_rx;
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule
